@@ sv/clx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_pkg - shared types and constants for the config token lexer
// Lexer modes, result kinds, error causes, character codes and the result
// record that travels from the lexer core to the output stage.
// ----------------------------------------------------------------------------
package clx_pkg;

    // Width of the number accumulator; results are sign-extended to OUT_NUM_W.
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_NUM_W   = 64;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_SIGN  = 3'd2,
        MODE_NUM   = 3'd3,
        MODE_STR   = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        K_ID_BYTE  = 4'd0,
        K_ID_END   = 4'd1,
        K_NUMBER   = 4'd2,
        K_STR_BYTE = 4'd3,
        K_STR_END  = 4'd4,
        K_ASSIGN   = 4'd5,
        K_NEWLINE  = 4'd6,
        K_COMMA    = 4'd7,
        K_EOF      = 4'd8,
        K_ERROR    = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_BAD_CHAR = 2'd0,
        CAUSE_NO_DIGIT = 2'd1,
        CAUSE_UNTERM   = 2'd2
    } t_cause;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             text;
        logic [OUT_NUM_W-1:0]   number;
        t_cause                 cause;
    } t_result;

endpackage
`default_nettype wire

@@ sv/clx_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_core - lexer state and single-step token logic
// Holds mode, accumulator and sign; for each fired byte produces up to two
// result records and the next state.
// ----------------------------------------------------------------------------
module clx_core
    import clx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_char,
    input  wire logic        i_skip,
    output logic [1:0]       o_count,
    output t_result          o_res0,
    output t_result          o_res1
);

    t_mode                  r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_neg, n_neg;

    logic                   is_letter, is_digit, is_ws;
    logic [3:0]             digit_val;
    logic [VALUE_WIDTH-1:0] acc_next, signed_val;
    logic [OUT_NUM_W-1:0]   num_out;

    logic                   idle_v, idle_digit;
    t_result                idle_res;
    t_mode                  idle_mode;

    logic                   lead_v, chain;
    t_result                lead;

    // Character classes
    assign is_letter = ((i_char >= CH_UPA) && (i_char <= CH_UPZ))
                    || ((i_char >= CH_LOA) && (i_char <= CH_LOZ))
                    || (i_char == CH_UNDER);
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_ws     = (i_char inside {CH_SPACE, CH_TAB, CH_CR})
                    || ((i_char == CH_LF) && i_skip);
    assign digit_val = 4'(i_char - CH_ZERO);

    // acc * 10 + digit as two shifts and adds, wrapping at VALUE_WIDTH
    assign acc_next = {r_acc[VALUE_WIDTH-4:0], 3'b000}
                    + {r_acc[VALUE_WIDTH-2:0], 1'b0}
                    + VALUE_WIDTH'(digit_val);
    assign signed_val = r_neg ? (VALUE_WIDTH'(0) - r_acc) : r_acc;
    assign num_out    = OUT_NUM_W'($signed(signed_val));

    // Token start: what a byte does when seen in idle mode
    always_comb begin
        idle_v     = 1'b0;
        idle_res   = '0;
        idle_mode  = MODE_IDLE;
        idle_digit = 1'b0;
        if (is_ws) begin
            idle_v = 1'b0;
        end else if (i_char == CH_NUL) begin
            idle_v        = 1'b1;
            idle_res.kind = K_EOF;
        end else if (is_letter) begin
            idle_v        = 1'b1;
            idle_res.kind = K_ID_BYTE;
            idle_res.text = i_char;
            idle_mode     = MODE_IDENT;
        end else if (is_digit) begin
            idle_digit = 1'b1;
            idle_mode  = MODE_NUM;
        end else if (i_char == CH_MINUS) begin
            idle_mode = MODE_SIGN;
        end else if (i_char == CH_QUOTE) begin
            idle_mode = MODE_STR;
        end else if (i_char == CH_EQ) begin
            idle_v        = 1'b1;
            idle_res.kind = K_ASSIGN;
        end else if (i_char == CH_LF) begin
            idle_v        = 1'b1;
            idle_res.kind = K_NEWLINE;
        end else if (i_char == CH_COMMA) begin
            idle_v        = 1'b1;
            idle_res.kind = K_COMMA;
        end else begin
            idle_v         = 1'b1;
            idle_res.kind  = K_ERROR;
            idle_res.cause = CAUSE_BAD_CHAR;
        end
    end

    // Mode-specific handling; chain hands the byte on to token start
    always_comb begin
        lead_v = 1'b0;
        lead   = '0;
        chain  = 1'b0;
        n_mode = r_mode;
        n_acc  = r_acc;
        n_neg  = r_neg;
        case (r_mode)
            MODE_IDENT: begin
                lead_v = 1'b1;
                if (is_letter || (i_char == CH_MINUS)) begin
                    lead.kind = K_ID_BYTE;
                    lead.text = i_char;
                end else begin
                    lead.kind = K_ID_END;
                    chain     = 1'b1;
                end
            end
            MODE_SIGN: begin
                if (is_digit) begin
                    n_acc  = VALUE_WIDTH'(digit_val);
                    n_neg  = 1'b1;
                    n_mode = MODE_NUM;
                end else begin
                    lead_v     = 1'b1;
                    lead.kind  = K_ERROR;
                    lead.cause = CAUSE_NO_DIGIT;
                    chain      = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit) begin
                    n_acc = acc_next;
                end else begin
                    lead_v      = 1'b1;
                    lead.kind   = K_NUMBER;
                    lead.number = num_out;
                    chain       = 1'b1;
                end
            end
            MODE_STR: begin
                lead_v = 1'b1;
                if (i_char == CH_QUOTE) begin
                    lead.kind = K_STR_END;
                    n_mode    = MODE_IDLE;
                end else if (i_char == CH_NUL) begin
                    lead.kind  = K_ERROR;
                    lead.cause = CAUSE_UNTERM;
                    chain      = 1'b1;
                end else begin
                    lead.kind = K_STR_BYTE;
                    lead.text = i_char;
                end
            end
            default: begin
                chain = 1'b1;
            end
        endcase
        if (chain) begin
            n_mode = idle_mode;
            if (idle_digit) begin
                n_acc = VALUE_WIDTH'(digit_val);
                n_neg = 1'b0;
            end
        end
    end

    // Pack the results in emission order
    always_comb begin
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        if (lead_v) begin
            o_res0 = lead;
            if (chain && idle_v) begin
                o_res1  = idle_res;
                o_count = 2'd2;
            end else begin
                o_count = 2'd1;
            end
        end else if (chain && idle_v) begin
            o_res0  = idle_res;
            o_count = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_neg  <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_neg  <= n_neg;
        end
    end

    a_pair_not_eof_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_count == 2'd2) |-> (o_res0.kind != K_EOF))
        else $error("two-result step led with eof");

    a_unterm_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_mode == MODE_STR) && (i_char == CH_NUL)) |=> (r_mode == MODE_IDLE))
        else $error("unterminated string did not return to idle");

endmodule
`default_nettype wire

@@ sv/clx_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clx_out - result register and serializer
// Holds the one or two results of a step and presents them one per request.
// ----------------------------------------------------------------------------
module clx_out
    import clx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [1:0]  i_count,
    input  wire t_result     i_res0,
    input  wire t_result     i_res1,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_result          o_res,
    output logic             o_last,
    output logic             o_free
);

    logic    r_pv, r_two, r_idx;
    t_result r_res0, r_res1;
    logic    show_last;

    assign show_last = !r_two || r_idx;
    assign o_valid   = r_pv;
    assign o_res     = r_idx ? r_res1 : r_res0;
    assign o_last    = show_last;
    assign o_free    = !r_pv || (i_ready && show_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_two <= 1'b0;
            r_idx <= 1'b0;
        end else if (i_load) begin
            r_pv  <= 1'b1;
            r_two <= (i_count == 2'd2);
            r_idx <= 1'b0;
        end else if (r_pv && i_ready) begin
            if (show_last) begin
                r_pv  <= 1'b0;
                r_idx <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_res0;
            r_res1 <= i_res1;
        end
    end

    a_idx_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx |-> (r_two && r_pv))
        else $error("second slot selected without a pair");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result register overwritten before drained");

endmodule
`default_nettype wire

@@ sv/config_token_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// config_token_lexer - byte-stream lexer for a key=value config language
// One byte in per request; token events out per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one byte (0 = end of input)
//   and the skip_newlines flag. Output channel o_out_valid / i_out_ready
//   carries one token event: kind, text byte, number, error cause and a last
//   flag marking the final event caused by that byte.
//   A byte is held in an input register, then the token logic writes its
//   results into the result register, from which the first event is
//   presented. Throughput: one byte per cycle while each byte makes zero
//   or one event and the receiver is ready; a byte that makes two events
//   (a terminator that also starts a token, or an error followed by eof)
//   occupies the result register for two output requests. Bytes that make
//   no event (whitespace, digits, opening quote, minus) step the lexer even
//   while results wait downstream.
//   Reset clears the mode to idle, the accumulator and sign, and empties the
//   input and result registers.
//   When the receiver stalls, hold the current event; the input register
//   fills and o_in_ready drops once a byte with events is waiting.
// ----------------------------------------------------------------------------
module config_token_lexer
    import clx_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_char_in,
    input  wire logic               i_skip_newlines,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [3:0]              o_kind,
    output logic [7:0]              o_text_byte,
    output logic signed [63:0]      o_number_value,
    output logic [1:0]              o_error_cause,
    output logic                    o_last
);

    // Input register
    logic       r_iv;
    logic [7:0] r_char;
    logic       r_skip;

    logic       fire, out_free, load;
    logic [1:0] step_count;
    t_result    step_res0, step_res1, out_res;

    // Fire the step when the result register can take it, or when the byte
    // makes no event at all.
    assign fire       = r_iv && (out_free || (step_count == 2'd0));
    assign load       = fire && (step_count != 2'd0);
    assign o_in_ready = !r_iv || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_iv <= 1'b1;
        end else if (fire) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_in;
            r_skip <= i_skip_newlines;
        end
    end

    clx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_char),
        .i_skip  (r_skip),
        .o_count (step_count),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    clx_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_count (step_count),
        .i_res0  (step_res0),
        .i_res1  (step_res1),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_last  (o_last),
        .o_free  (out_free)
    );

    assign o_kind         = 4'(out_res.kind);
    assign o_text_byte    = out_res.text;
    assign o_number_value = $signed(out_res.number);
    assign o_error_cause  = 2'(out_res.cause);

    a_input_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iv && out_free) |=> (!r_iv || $past(i_in_valid && o_in_ready)))
        else $error("byte held although the step could fire");

endmodule
`default_nettype wire
